// ----- rtl/core/csw_pkg.sv -----
// Shared types and constants for the clock, alarm and stopwatch core.
// Used by csw_scale, csw_next, clock_alarm_stopwatch_core and the testbench; no dependencies.
`timescale 1ns / 1ps

package csw_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_BTN_A  = 2'd1,
      CMD_BTN_B  = 2'd2,
      CMD_SAMPLE = 2'd3
   } cmd_type;

   localparam logic [1:0] MODE_CLOCK     = 2'd0;
   localparam logic [1:0] MODE_ALARM_SET = 2'd1;
   localparam logic [1:0] MODE_CLOCK_SET = 2'd2;

   localparam logic [1:0] WAKE_STEP_HOUR   = 2'd0;
   localparam logic [1:0] WAKE_STEP_MINUTE = 2'd1;
   localparam logic [1:0] WAKE_STEP_DONE   = 2'd2;
   localparam logic [1:0] WAKE_STEP_IDLE   = 2'd3;

   localparam logic [2:0] TIME_STEP_HOUR   = 3'd0;
   localparam logic [2:0] TIME_STEP_MINUTE = 3'd1;
   localparam logic [2:0] TIME_STEP_SECOND = 3'd2;
   localparam logic [2:0] TIME_STEP_DONE   = 3'd3;
   localparam logic [2:0] TIME_STEP_IDLE   = 3'd4;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
   localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
   localparam logic [5:0] HOUR_MAX           = 6'd23;
   localparam logic [5:0] MINUTE_MAX         = 6'd59;

   localparam logic [5:0] ALARM_DURATION_RESET = 6'd6;
   localparam logic [1:0] ADDR_ALARM_DURATION  = 2'd0;

   // Fixed-point shift for the constant-reciprocal scaling of samples.
   localparam int SCALE_SHIFT = 24;
   localparam int POT_WIDTH   = 10;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } hms_type;

   typedef struct packed {
      hms_type    time_now;
      logic [4:0] wake_hour;
      logic [5:0] wake_minute;
      hms_type    lap;
      logic [1:0] mode;
      logic [1:0] wake_step;
      logic [2:0] time_step;
      logic       ringing;
   } state_type;

   localparam state_type STATE_RESET = '{
      time_now:    '{hour: 5'd12, minute: 6'd30, second: 6'd40},
      wake_hour:   5'd12,
      wake_minute: 6'd30,
      lap:         '{hour: 5'd0, minute: 6'd0, second: 6'd0},
      mode:        MODE_CLOCK,
      wake_step:   WAKE_STEP_IDLE,
      time_step:   TIME_STEP_IDLE,
      ringing:     1'b0
   };

   // Result word, highest field first; the clock hour sits in the lowest bits.
   function automatic logic [47:0] pack_result(input state_type s);
      pack_result = {s.ringing, s.mode,
                     s.lap.second, s.lap.minute, s.lap.hour,
                     s.wake_minute, s.wake_hour,
                     s.time_now.second, s.time_now.minute, s.time_now.hour};
   endfunction

endpackage

// ----- rtl/core/csw_scale.sv -----
// Maps a potentiometer sample onto 0..23 or 0..59 as value*max/POT_MAX, truncated.
// Uses one multiply by a ceiling reciprocal, exact for 10-bit samples. Depends on csw_pkg.
`timescale 1ns / 1ps

module csw_scale import csw_pkg::*; #(
   parameter int POT_MAX = 1023
) (
   input  logic [POT_WIDTH-1:0] pot_value,
   input  logic                 sel_minute,
   output logic [5:0]           scaled
);

   localparam longint unsigned K_HOUR =
      ((longint'(HOUR_MAX) << SCALE_SHIFT) + longint'(POT_MAX) - 1) / longint'(POT_MAX);
   localparam longint unsigned K_MINUTE =
      ((longint'(MINUTE_MAX) << SCALE_SHIFT) + longint'(POT_MAX) - 1) / longint'(POT_MAX);
   localparam int KW = $clog2(K_MINUTE + 1);
   localparam int PW = POT_WIDTH + KW;

   logic [KW-1:0] factor;
   logic [PW-1:0] product;
   logic [PW-1:0] quotient;
   logic [5:0]    top;

   always_comb begin
      factor   = sel_minute ? KW'(K_MINUTE) : KW'(K_HOUR);
      top      = sel_minute ? MINUTE_MAX : HOUR_MAX;
      product  = PW'(pot_value) * PW'(factor);
      quotient = product >> SCALE_SHIFT;
      // Samples above POT_MAX would overshoot the field, so clamp them.
      if (quotient > PW'(top)) begin
         scaled = top;
      end else begin
         scaled = quotient[5:0];
      end
   end

endmodule

// ----- rtl/core/csw_next.sv -----
// Next-state logic for one event: tick counting, button stepping and sample setting.
// Depends on csw_pkg and csw_scale.
`timescale 1ns / 1ps

module csw_next import csw_pkg::*; #(
   parameter int POT_MAX = 1023
) (
   input  state_type            cur,
   input  cmd_type              cmd,
   input  logic [POT_WIDTH-1:0] pot_value,
   input  logic [5:0]           alarm_duration,
   output state_type            nxt
);

   logic       sel_minute;
   logic [5:0] scaled;
   logic [1:0] ws_inc;
   logic [2:0] ts_inc;
   logic [1:0] ws_next;
   logic [2:0] ts_next;

   function automatic hms_type advance(input hms_type t);
      hms_type    r;
      logic [6:0] s1;
      logic [6:0] m1;
      logic [5:0] h1;
      r  = t;
      s1 = {1'b0, t.second} + 7'd1;
      m1 = {1'b0, t.minute} + 7'd1;
      h1 = {1'b0, t.hour} + 6'd1;
      if (s1 >= {1'b0, SECONDS_PER_MINUTE}) begin
         r.second = '0;
         if (m1 >= {1'b0, MINUTES_PER_HOUR}) begin
            r.minute = '0;
            r.hour   = (h1 >= {1'b0, HOURS_PER_DAY}) ? 5'd0 : h1[4:0];
         end else begin
            r.minute = m1[5:0];
         end
      end else begin
         r.second = s1[5:0];
      end
      return r;
   endfunction

   // Only the hour fields use the 0..23 range.
   assign sel_minute = (cur.mode == MODE_ALARM_SET) ? (cur.wake_step != WAKE_STEP_HOUR)
                                                     : (cur.time_step != TIME_STEP_HOUR);

   csw_scale #(.POT_MAX(POT_MAX)) u_scale (
      .pot_value  (pot_value),
      .sel_minute (sel_minute),
      .scaled     (scaled)
   );

   always_comb begin
      ws_inc  = cur.wake_step + 2'd1;
      ws_next = (ws_inc > WAKE_STEP_DONE) ? WAKE_STEP_HOUR : ws_inc;
      ts_inc  = cur.time_step + 3'd1;
      ts_next = (ts_inc > TIME_STEP_DONE) ? TIME_STEP_HOUR : ts_inc;
   end

   always_comb begin
      nxt = cur;
      case (cmd)
         CMD_TICK: begin
            if (cur.mode != MODE_CLOCK_SET) begin
               nxt.time_now = advance(cur.time_now);
            end
            nxt.lap     = advance(cur.lap);
            nxt.ringing = (nxt.time_now.hour == cur.wake_hour) &&
                          (nxt.time_now.minute == cur.wake_minute) &&
                          (nxt.time_now.second < alarm_duration);
         end
         CMD_BTN_A: begin
            if (cur.mode == MODE_CLOCK || cur.mode == MODE_ALARM_SET) begin
               nxt.wake_step = ws_next;
               nxt.mode      = (ws_next == WAKE_STEP_DONE) ? MODE_CLOCK : MODE_ALARM_SET;
            end else if (cur.mode == MODE_CLOCK_SET) begin
               nxt.time_step = ts_next;
               nxt.mode      = (ts_next == TIME_STEP_DONE) ? MODE_CLOCK : MODE_CLOCK_SET;
            end
         end
         CMD_BTN_B: begin
            if (cur.mode == MODE_ALARM_SET) begin
               nxt.time_step = ts_next;
               nxt.mode      = (ts_next == TIME_STEP_DONE) ? MODE_CLOCK : MODE_CLOCK_SET;
            end
         end
         default: begin
            if (cur.mode == MODE_ALARM_SET) begin
               if (cur.wake_step == WAKE_STEP_HOUR) begin
                  nxt.wake_hour = scaled[4:0];
               end else if (cur.wake_step == WAKE_STEP_MINUTE) begin
                  nxt.wake_minute = scaled;
               end
            end else if (cur.mode == MODE_CLOCK_SET) begin
               if (cur.time_step == TIME_STEP_HOUR) begin
                  nxt.time_now.hour = scaled[4:0];
               end else if (cur.time_step == TIME_STEP_MINUTE) begin
                  nxt.time_now.minute = scaled;
               end else if (cur.time_step == TIME_STEP_SECOND) begin
                  nxt.time_now.second = scaled;
               end
            end
         end
      endcase
   end

endmodule

// ----- rtl/core/clock_alarm_stopwatch_core.sv -----
// Clock, alarm and stopwatch core: one event in, one snapshot of the state out.
// The state register doubles as the result register; a result is valid in the cycle
// after its transfer. Throughput: one item per cycle while rsp_tready is high.
// Reset (synchronous): clock 12:30:40, alarm 12:30, stopwatch zero, clock display,
// alarm duration 6 seconds, no result pending.
`timescale 1ns / 1ps

module clock_alarm_stopwatch_core import csw_pkg::*; #(
   parameter int POT_MAX = 1023
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] pot_value, [15:10] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] clock_hour, [10:5] clock_minute, [16:11] clock_second, [21:17] alarm_hour,
   // [27:22] alarm_minute, [32:28] watch_hour, [38:33] watch_minute,
   // [44:39] watch_second, [46:45] screen_mode, [47] alarm_active
   output logic [47:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type  state_ff;
   state_type  state_in;
   state_type  state_calc;
   logic       valid_ff;
   logic       valid_in;
   logic [5:0] duration_ff;
   logic [5:0] duration_in;
   logic       req_xfer;
   logic       csr_write;

   assign req_tready = !valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   // The state only changes on a transfer, so it always shows the last result.
   assign rsp_tdata  = pack_result(state_ff);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == ADDR_ALARM_DURATION) ? {26'd0, duration_ff} : 32'd0;

   csw_next #(.POT_MAX(POT_MAX)) u_next (
      .cur            (state_ff),
      .cmd            (cmd_type'(req_tuser)),
      .pot_value      (req_tdata[POT_WIDTH-1:0]),
      .alarm_duration (duration_ff),
      .nxt            (state_calc)
   );

   always_comb begin
      state_in    = req_xfer ? state_calc : state_ff;
      valid_in    = req_xfer ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      duration_in = (csr_write && csr_paddr == ADDR_ALARM_DURATION) ? csr_pwdata[5:0]
                                                                     : duration_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_RESET;
         valid_ff    <= 1'b0;
         duration_ff <= ALARM_DURATION_RESET;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         duration_ff <= duration_in;
      end
   end

endmodule

// ----- verif/tb_clock_alarm_stopwatch_core.sv -----
// Self-checking testbench for clock_alarm_stopwatch_core: drives tick, button and sample events
// with random idling on both streams, predicts every display snapshot and compares it.
// Depends on csw_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_clock_alarm_stopwatch_core;
   import csw_pkg::*;

   localparam int POT_FULL = 1023;

   // Display snapshot in result-word order, highest field first.
   typedef struct packed {
      logic       alarm_active;
      logic [1:0] screen_mode;
      logic [5:0] watch_second;
      logic [5:0] watch_minute;
      logic [4:0] watch_hour;
      logic [5:0] alarm_minute;
      logic [4:0] alarm_hour;
      logic [5:0] clock_second;
      logic [5:0] clock_minute;
      logic [4:0] clock_hour;
   } snapshot_t;

   class display_tracker;
      hms_type    clk_now;
      hms_type    lap;
      logic [4:0] wake_hour;
      logic [5:0] wake_minute;
      logic [1:0] mode;
      logic [1:0] wake_step;
      logic [2:0] time_step;
      logic       ringing;
      logic [5:0] duration;
      snapshot_t  awaited[$];
      int         errors;
      int         checked;

      function new();
         clk_now     = '{hour: 5'd12, minute: 6'd30, second: 6'd40};
         lap         = '{hour: 5'd0, minute: 6'd0, second: 6'd0};
         wake_hour   = 5'd12;
         wake_minute = 6'd30;
         mode        = MODE_CLOCK;
         wake_step   = WAKE_STEP_IDLE;
         time_step   = TIME_STEP_IDLE;
         ringing     = 1'b0;
         duration    = ALARM_DURATION_RESET;
         errors      = 0;
         checked     = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function hms_type one_second_on(hms_type t);
         t.second = t.second + 6'd1;
         if (t.second >= SECONDS_PER_MINUTE) begin
            t.second = 6'd0;
            t.minute = t.minute + 6'd1;
            if (t.minute >= MINUTES_PER_HOUR) begin
               t.minute = 6'd0;
               t.hour   = t.hour + 5'd1;
               if (t.hour >= HOURS_PER_DAY)
                  t.hour = 5'd0;
            end
         end
         return t;
      endfunction

      function logic [5:0] scaled(logic [9:0] pot, int top);
         int r;
         r = (int'(pot) * top) / POT_FULL;
         if (r > top)
            r = top;
         return 6'(r);
      endfunction

      function void step_wake();
         wake_step = wake_step + 2'd1;
         if (wake_step == WAKE_STEP_IDLE)
            wake_step = WAKE_STEP_HOUR;
         if (wake_step == WAKE_STEP_DONE)
            mode = MODE_CLOCK;
      endfunction

      function void step_time();
         time_step = time_step + 3'd1;
         if (time_step > TIME_STEP_DONE)
            time_step = TIME_STEP_HOUR;
         if (time_step == TIME_STEP_DONE)
            mode = MODE_CLOCK;
      endfunction

      // Applies one accepted event and queues the snapshot the block must return for it.
      function void note_event(cmd_type c, logic [9:0] pot);
         snapshot_t s;
         case (c)
            CMD_TICK: begin
               if (mode != MODE_CLOCK_SET)
                  clk_now = one_second_on(clk_now);
               lap = one_second_on(lap);
               ringing = (clk_now.hour == wake_hour && clk_now.minute == wake_minute &&
                          clk_now.second < duration);
            end
            CMD_BTN_A: begin
               if (mode == MODE_CLOCK) begin
                  mode = MODE_ALARM_SET;
                  step_wake();
               end else if (mode == MODE_ALARM_SET) begin
                  step_wake();
               end else if (mode == MODE_CLOCK_SET) begin
                  step_time();
               end
            end
            CMD_BTN_B: begin
               if (mode == MODE_ALARM_SET) begin
                  mode = MODE_CLOCK_SET;
                  step_time();
               end
            end
            default: begin
               if (mode == MODE_ALARM_SET) begin
                  if (wake_step == WAKE_STEP_HOUR)
                     wake_hour = 5'(scaled(pot, HOUR_MAX));
                  else if (wake_step == WAKE_STEP_MINUTE)
                     wake_minute = scaled(pot, MINUTE_MAX);
               end else if (mode == MODE_CLOCK_SET) begin
                  if (time_step == TIME_STEP_HOUR)
                     clk_now.hour = 5'(scaled(pot, HOUR_MAX));
                  else if (time_step == TIME_STEP_MINUTE)
                     clk_now.minute = scaled(pot, MINUTE_MAX);
                  else if (time_step == TIME_STEP_SECOND)
                     clk_now.second = scaled(pot, MINUTE_MAX);
               end
            end
         endcase
         s.clock_hour   = clk_now.hour;
         s.clock_minute = clk_now.minute;
         s.clock_second = clk_now.second;
         s.alarm_hour   = wake_hour;
         s.alarm_minute = wake_minute;
         s.watch_hour   = lap.hour;
         s.watch_minute = lap.minute;
         s.watch_second = lap.second;
         s.screen_mode  = mode;
         s.alarm_active = ringing;
         awaited.push_back(s);
      endfunction

      task report(string msg);
         if (errors < 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task match_field(string name, int got, int want);
         if (got != want)
            report($sformatf("result %0d %s = %0d, expected %0d", checked, name, got, want));
      endtask

      task check_display(logic [47:0] word);
         snapshot_t got;
         snapshot_t want;
         if (awaited.size() == 0) begin
            report($sformatf("result %0d arrived with nothing awaited", checked));
            checked++;
            return;
         end
         got  = snapshot_t'(word);
         want = awaited.pop_front();
         match_field("clock_hour", got.clock_hour, want.clock_hour);
         match_field("clock_minute", got.clock_minute, want.clock_minute);
         match_field("clock_second", got.clock_second, want.clock_second);
         match_field("alarm_hour", got.alarm_hour, want.alarm_hour);
         match_field("alarm_minute", got.alarm_minute, want.alarm_minute);
         match_field("watch_hour", got.watch_hour, want.watch_hour);
         match_field("watch_minute", got.watch_minute, want.watch_minute);
         match_field("watch_second", got.watch_second, want.watch_second);
         match_field("screen_mode", got.screen_mode, want.screen_mode);
         match_field("alarm_active", got.alarm_active, want.alarm_active);
         checked++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [9:0] pot_value, [15:10] zero
   logic [1:0]  req_tuser = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // clock h/m/s, alarm h/m, watch h/m/s, mode, alarm flag
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   display_tracker board;
   int sent_count = 0;
   int recv_count = 0;
   bit steady = 1'b0;   // no idling on either side while set

   clock_alarm_stopwatch_core #(.POT_MAX(POT_FULL)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_display(rsp_tdata);
   end

   // Result side: a fresh stall is drawn before every result transfer.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = (steady || (recv_count % 130) < 25) ? 0 : $urandom_range(0, 19);
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         recv_count++;
      end
   end

   task automatic send_event(cmd_type c, logic [9:0] pot);
      int gap;
      gap = (steady || (sent_count % 160) < 30) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {6'd0, pot};
      do @(posedge clock); while (!req_tready);
      board.note_event(c, pot);
      sent_count++;
   endtask

   task automatic press(cmd_type c);
      send_event(c, 10'($urandom_range(0, POT_FULL)));
   endtask

   function automatic int pot_floor(int v, int top);
      return (v * POT_FULL + top - 1) / top;
   endfunction

   // Picks a random reading inside the band that scales to the wanted value.
   task automatic load_field(int v, int top);
      int lo;
      int hi;
      lo = pot_floor(v, top);
      hi = (v >= top) ? POT_FULL : pot_floor(v + 1, top) - 1;
      send_event(CMD_SAMPLE, 10'($urandom_range(lo, hi)));
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0)
         send_event(cmd_type'($urandom_range(0, 3)), 10'($urandom_range(0, POT_FULL)));
   endtask

   task automatic tick_burst(int n);
      repeat (n) press(CMD_TICK);
   endtask

   task automatic set_alarm(int h, int m);
      while (!(board.mode == MODE_ALARM_SET && board.wake_step == WAKE_STEP_HOUR))
         press(CMD_BTN_A);
      maybe_noise();
      load_field(h, HOUR_MAX);
      press(CMD_BTN_A);
      maybe_noise();
      load_field(m, MINUTE_MAX);
      press(CMD_BTN_A);
   endtask

   task automatic set_clock(int h, int m, int s);
      while (!(board.mode == MODE_CLOCK_SET && board.time_step == TIME_STEP_HOUR))
         press(board.mode == MODE_ALARM_SET ? CMD_BTN_B : CMD_BTN_A);
      load_field(h, HOUR_MAX);
      tick_burst($urandom_range(0, 2));   // the clock must stay frozen here
      press(CMD_BTN_A);
      maybe_noise();
      load_field(m, MINUTE_MAX);
      press(CMD_BTN_A);
      load_field(s, MINUTE_MAX);
      press(CMD_BTN_A);
   endtask

   task automatic run_mix(int n);
      int start;
      int pick;
      int m;
      start = sent_count;
      while (sent_count - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // Mostly an alarm on the current or the coming minute, so that it goes off soon; else a random one.
            m = (board.clk_now.minute + $urandom_range(0, 1)) % 60;
            if ($urandom_range(0, 4) == 0)
               set_alarm($urandom_range(0, 23), $urandom_range(0, 59));
            else
               set_alarm(board.clk_now.hour, m);
            tick_burst($urandom_range(0, 70));
         end else if (pick < 50) begin
            // Clock just before or inside the alarm minute, or a random time when the alarm minute is zero.
            if ($urandom_range(0, 1) == 0)
               set_clock(board.wake_hour, board.wake_minute, $urandom_range(0, 59));
            else if (board.wake_minute > 0)
               set_clock(board.wake_hour, board.wake_minute - 1, $urandom_range(45, 59));
            else
               set_clock($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
            tick_burst($urandom_range(0, 70));
         end else if (pick < 70) begin
            tick_burst($urandom_range(1, 80));
         end else begin
            send_event(cmd_type'($urandom_range(0, 3)), 10'($urandom_range(0, POT_FULL)));
         end
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(logic [5:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_ALARM_DURATION;
      csr_pwdata  <= {26'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      board.duration = v;
   endtask

   task automatic csr_check();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_ALARM_DURATION;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {26'd0, board.duration})
         board.report($sformatf("alarm_duration read %0d, expected %0d",
                                csr_prdata, board.duration));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check();

      // Directed part: ignored events, field extremes, frozen clock, day wrap into the alarm.
      press(CMD_BTN_B);
      send_event(CMD_SAMPLE, 10'd1023);
      press(CMD_BTN_A);
      send_event(CMD_SAMPLE, 10'd1023);
      send_event(CMD_SAMPLE, 10'd0);
      press(CMD_TICK);
      press(CMD_BTN_A);
      send_event(CMD_SAMPLE, 10'd1023);
      send_event(CMD_SAMPLE, 10'd0);
      press(CMD_BTN_B);
      send_event(CMD_SAMPLE, 10'd1023);
      press(CMD_TICK);
      press(CMD_BTN_A);
      send_event(CMD_SAMPLE, 10'd1023);
      press(CMD_BTN_A);
      send_event(CMD_SAMPLE, 10'd1023);
      press(CMD_BTN_B);
      press(CMD_TICK);
      press(CMD_BTN_A);
      press(CMD_TICK);
      press(CMD_TICK);
      // Alarm entry from a step that closes the setting at once.
      press(CMD_BTN_A);
      press(CMD_BTN_A);
      send_event(CMD_SAMPLE, 10'd512);
      press(CMD_BTN_A);
      settle();

      csr_write(6'd1);
      csr_check();
      run_mix(500);
      settle();

      csr_write(6'd59);
      csr_check();
      run_mix(500);
      settle();

      // A zero duration must never ring.
      csr_write(6'd0);
      csr_check();
      run_mix(250);
      settle();

      csr_write(6'($urandom_range(1, 59)));
      csr_check();
      run_mix(200);
      settle();   // sender holds off until every snapshot is back
      run_mix(200);
      settle();

      // Back-to-back ticks carry the clock across midnight.
      csr_write(6'd59);
      set_clock(23, 59, 50);
      steady = 1'b1;
      tick_burst(40);
      steady = 1'b0;
      settle();

      if (board.pending() != 0)
         board.report($sformatf("%0d snapshots never arrived", board.pending()));
      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
